[hw/rtl/bbhc_pkg.sv]
// ----------------------------------------------------------------------------
// bbhc_pkg
// Shared types, constants and the CRC-8 step for the bus bridge header codec.
// ----------------------------------------------------------------------------
package bbhc_pkg;

   localparam int HeaderBytes = 12;
   localparam logic [3:0] LastIdx = 4'(HeaderBytes - 1);
   localparam logic [7:0] CrcInit = 8'hFF;
   localparam logic [7:0] CrcPoly = 8'h07;

   localparam logic FuncRequest = 1'b0;
   localparam logic FuncReply   = 1'b1;

   localparam logic KindHeader = 1'b0;
   localparam logic KindStatus = 1'b1;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_ID      = 3'd1,
      ST_CRC     = 3'd2,
      ST_CORRUPT = 3'd3,
      ST_TIMEOUT = 3'd4,
      ST_LENGTH  = 3'd5
   } status_type;

   // One unit of work handed from the front to the back.
   typedef struct packed {
      logic        is_status;
      status_type  status;
      logic [31:0] address;
      logic [31:0] length;
      logic [15:0] mode;
      logic [7:0]  id;
   } job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // CRC-8, poly 0x07, MSB first, one byte.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[hw/rtl/bbhc_front.sv]
// ----------------------------------------------------------------------------
// bbhc_front
// Accepts request and reply words, tracks the transaction id and checks the
// reply header, queuing one job per request and one per completed reply.
// ----------------------------------------------------------------------------
module bbhc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      func,
   input  logic                      is_write,
   input  logic [15:0]               access_mode,
   input  logic [31:0]               bus_address,
   input  logic [31:0]               byte_count,
   input  logic [7:0]                reply_byte,
   output logic                      push,
   output bbhc_pkg::job_type         push_job
);

   logic [7:0]  trans_id_ff, trans_id_in;
   logic [31:0] pending_len_ff, pending_len_in;
   logic        pending_read_ff, pending_read_in;
   logic [3:0]  reply_count_ff, reply_count_in;
   logic [7:0]  reply_crc_ff, reply_crc_in;
   logic [31:0] reply_len_ff, reply_len_in;
   logic [7:0]  reply_id_ff, reply_id_in;
   logic [7:0]  reply_flags_ff, reply_flags_in;
   bbhc_pkg::status_type check;

   always_comb begin
      if (reply_id_ff != trans_id_ff) begin
         check = bbhc_pkg::ST_ID;
      end else if (reply_crc_ff != reply_byte) begin
         check = bbhc_pkg::ST_CRC;
      end else if (reply_flags_ff[0]) begin
         check = bbhc_pkg::ST_CORRUPT;
      end else if (reply_flags_ff[2]) begin
         check = bbhc_pkg::ST_TIMEOUT;
      end else if (pending_read_ff && (reply_len_ff != pending_len_ff)) begin
         check = bbhc_pkg::ST_LENGTH;
      end else begin
         check = bbhc_pkg::ST_OK;
      end
   end

   always_comb begin
      trans_id_in     = trans_id_ff;
      pending_len_in  = pending_len_ff;
      pending_read_in = pending_read_ff;
      reply_count_in  = reply_count_ff;
      reply_crc_in    = reply_crc_ff;
      reply_len_in    = reply_len_ff;
      reply_id_in     = reply_id_ff;
      reply_flags_in  = reply_flags_ff;
      push            = 1'b0;
      push_job.is_status = 1'b0;
      push_job.status    = bbhc_pkg::ST_OK;
      push_job.address   = bus_address;
      push_job.length    = byte_count;
      push_job.mode      = {access_mode[15] | is_write, access_mode[14:0]};
      push_job.id        = trans_id_ff;
      if (accept && (func == bbhc_pkg::FuncRequest)) begin
         // new request drops any partial reply
         push            = 1'b1;
         pending_len_in  = byte_count;
         pending_read_in = ~is_write;
         reply_count_in  = '0;
         reply_crc_in    = bbhc_pkg::CrcInit;
      end else if (accept) begin
         if (reply_count_ff != bbhc_pkg::LastIdx) begin
            reply_crc_in   = bbhc_pkg::crc8_step(reply_crc_ff, reply_byte);
            reply_count_in = reply_count_ff + 4'd1;
         end
         if (reply_count_ff inside {[4'd4:4'd7]}) begin
            reply_len_in = {reply_len_ff[23:0], reply_byte};
         end
         if (reply_count_ff == 4'd9) begin
            reply_flags_in = reply_byte;
         end
         if (reply_count_ff == 4'd10) begin
            reply_id_in = reply_byte;
         end
         if (reply_count_ff == bbhc_pkg::LastIdx) begin
            push               = 1'b1;
            push_job.is_status = 1'b1;
            push_job.status    = check;
            reply_count_in     = '0;
            reply_crc_in       = bbhc_pkg::CrcInit;
            if (check == bbhc_pkg::ST_OK) begin
               trans_id_in = trans_id_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_id_ff     <= '0;
         pending_len_ff  <= '0;
         pending_read_ff <= 1'b0;
         reply_count_ff  <= '0;
         reply_crc_ff    <= bbhc_pkg::CrcInit;
      end else begin
         trans_id_ff     <= trans_id_in;
         pending_len_ff  <= pending_len_in;
         pending_read_ff <= pending_read_in;
         reply_count_ff  <= reply_count_in;
         reply_crc_ff    <= reply_crc_in;
      end
   end

   always_ff @(posedge clock) begin
      reply_len_ff   <= reply_len_in;
      reply_id_ff    <= reply_id_in;
      reply_flags_ff <= reply_flags_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      reply_count_ff <= bbhc_pkg::LastIdx)
      else $error("reply byte count out of range");

endmodule

[hw/rtl/bbhc_queue.sv]
// ----------------------------------------------------------------------------
// bbhc_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module bbhc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bbhc_pkg::job_type          push_job,
   input  logic                       pop,
   output bbhc_pkg::job_type          head_job,
   output bbhc_pkg::queue_status_type stat
);

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   bbhc_pkg::job_type entries_ff [DEPTH];
   logic [IdxW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign stat.full      = (count_ff == CntW'(DEPTH));
   assign stat.not_empty = (count_ff != '0);
   assign head_job       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!stat.full || pop))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> stat.not_empty)
      else $error("job queue underflow");

endmodule

[hw/rtl/bbhc_back.sv]
// ----------------------------------------------------------------------------
// bbhc_back
// Expands queued jobs into result words: twelve header bytes with a running
// CRC-8 for a request, one status word for a checked reply.
// ----------------------------------------------------------------------------
module bbhc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  bbhc_pkg::job_type          head_job,
   input  bbhc_pkg::queue_status_type stat,
   output logic                       q_pop,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output logic                       rsp_out_kind,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last,
   output logic [2:0]                 rsp_status
);

   logic              busy_ff, busy_in;
   logic [3:0]        idx_ff, idx_in;
   logic [7:0]        crc_ff, crc_in;
   bbhc_pkg::job_type job_ff, job_in;
   logic              valid_ff, valid_in;
   logic              kind_ff, kind_in;
   logic [7:0]        byte_ff, byte_in;
   logic              last_ff, last_in;
   logic [2:0]        status_ff, status_in;

   bbhc_pkg::job_type cur_job;
   logic [3:0]        cur_idx;
   logic [7:0]        cur_crc;
   logic [7:0]        field_byte;
   logic              out_ready;
   logic              fire;

   assign out_ready = !valid_ff || rsp_pop;
   assign cur_job   = busy_ff ? job_ff : head_job;
   assign cur_idx   = busy_ff ? idx_ff : 4'd0;
   assign cur_crc   = busy_ff ? crc_ff : bbhc_pkg::CrcInit;
   assign fire      = (busy_ff || stat.not_empty) && out_ready;
   assign q_pop     = fire && !busy_ff;

   always_comb begin
      case (cur_idx)
         4'd0:    field_byte = cur_job.address[31:24];
         4'd1:    field_byte = cur_job.address[23:16];
         4'd2:    field_byte = cur_job.address[15:8];
         4'd3:    field_byte = cur_job.address[7:0];
         4'd4:    field_byte = cur_job.length[31:24];
         4'd5:    field_byte = cur_job.length[23:16];
         4'd6:    field_byte = cur_job.length[15:8];
         4'd7:    field_byte = cur_job.length[7:0];
         4'd8:    field_byte = cur_job.mode[15:8];
         4'd9:    field_byte = cur_job.mode[7:0];
         4'd10:   field_byte = cur_job.id;
         default: field_byte = cur_crc;
      endcase
   end

   always_comb begin
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      job_in    = job_ff;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      status_in = status_ff;
      valid_in  = rsp_pop ? 1'b0 : valid_ff;
      if (fire) begin
         valid_in = 1'b1;
         if (cur_job.is_status) begin
            kind_in   = bbhc_pkg::KindStatus;
            byte_in   = '0;
            last_in   = 1'b0;
            status_in = cur_job.status;
         end else begin
            kind_in   = bbhc_pkg::KindHeader;
            byte_in   = field_byte;
            status_in = bbhc_pkg::ST_OK;
            last_in   = (cur_idx == bbhc_pkg::LastIdx);
            crc_in    = bbhc_pkg::crc8_step(cur_crc, field_byte);
            job_in    = cur_job;
            idx_in    = cur_idx + 4'd1;
            busy_in   = (cur_idx != bbhc_pkg::LastIdx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      crc_ff    <= crc_in;
      job_ff    <= job_in;
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign rsp_empty    = !valid_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;
   assign rsp_status   = status_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff != 4'd0) && (idx_ff <= bbhc_pkg::LastIdx))
      else $error("header byte index out of range while busy");

   a_start_header: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !head_job.is_status) |=> busy_ff && (idx_ff == 4'd1))
      else $error("request job did not start header expansion");

   a_hold_busy: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !out_ready) |=> busy_ff && $stable(idx_ff))
      else $error("header expansion advanced while output stalled");

endmodule

[hw/rtl/bus_bridge_header_codec_core.sv]
// ----------------------------------------------------------------------------
// bus_bridge_header_codec_core
// Host-side request/reply header engine: builds CRC-8 protected request
// headers and checks reply headers for a bus-over-Ethernet bridge.
// ----------------------------------------------------------------------------
//  channel   ports                              accepted when
//  request   req_push / req_full, req_* fields  req_push && !req_full
//  result    rsp_empty / rsp_pop, rsp_* fields  rsp_pop && !rsp_empty
//
//  The twelfth reply word queues a status word.
//  A request occupies the back end for twelve header bytes, one header byte
//  per cycle unless the result output is stalled.
//  req_full rises only when the job queue (QUEUE_DEPTH jobs) is full.
//  Synchronous reset: id 0, no pending read, reply count 0, queue empty.
//  A stalled rsp_pop holds the back end; the front takes words until req_full.
// ----------------------------------------------------------------------------
module bus_bridge_header_codec_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic        req_is_write,
   input  logic [15:0] req_access_mode,
   input  logic [31:0] req_bus_address,
   input  logic [31:0] req_byte_count,
   input  logic [7:0]  req_reply_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic [2:0]  rsp_status
);

   logic                       accept;
   logic                       push;
   bbhc_pkg::job_type          push_job;
   logic                       q_pop;
   bbhc_pkg::job_type          head_job;
   bbhc_pkg::queue_status_type q_stat;

   assign req_full = q_stat.full;
   assign accept   = req_push && !q_stat.full;

   bbhc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (req_func),
      .is_write    (req_is_write),
      .access_mode (req_access_mode),
      .bus_address (req_bus_address),
      .byte_count  (req_byte_count),
      .reply_byte  (req_reply_byte),
      .push        (push),
      .push_job    (push_job)
   );

   bbhc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   bbhc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .stat         (q_stat),
      .q_pop        (q_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_status   (rsp_status)
   );

endmodule
